/* hw/rtl/hcdc_pkg.sv */
// Shared types and constants for the compressor and defrost controller.
package hcdc_pkg;

   localparam int TEMP_W = 12;
   localparam int TIME_W = 32;
   localparam int RUN_W  = 31;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      REG_ON_THRESHOLD  = 3'd0,
      REG_OFF_THRESHOLD = 3'd1,
      REG_MIN_RUN       = 3'd2,
      REG_DEF_INTERVAL  = 3'd3,
      REG_DEF_DURATION  = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ACT_HOLD       = 3'd0,
      ACT_START      = 3'd1,
      ACT_LOW_STOP   = 3'd2,
      ACT_MAX_STOP   = 3'd3,
      ACT_DEF_START  = 3'd4,
      ACT_DEFROSTING = 3'd5,
      ACT_DEF_END    = 3'd6
   } action_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] on_threshold;
      logic signed [TEMP_W-1:0] off_threshold;
      logic [RUN_W-1:0]         min_run_ms;
      logic [TIME_W-1:0]        defrost_interval_ms;
      logic [TIME_W-1:0]        defrost_duration_ms;
   } cfg_type;

   typedef struct packed {
      logic       compressor_on;
      logic       fan_on;
      logic       heater_on;
      action_type action;
   } result_type;

endpackage

/* hw/rtl/hcdc_csr.sv */
// Configuration register file with APB-style write and read access.
module hcdc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hcdc_pkg::ADDR_W-1:0]   paddr,
   input  logic [hcdc_pkg::DATA_W-1:0]   pwdata,
   output logic [hcdc_pkg::DATA_W-1:0]   prdata,
   output hcdc_pkg::cfg_type             cfg
);

   hcdc_pkg::cfg_type cfg_ff;
   hcdc_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        idx;

   assign wr_en = psel && penable && pwrite;
   assign idx   = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            hcdc_pkg::REG_ON_THRESHOLD:  cfg_in.on_threshold = pwdata[11:0];
            hcdc_pkg::REG_OFF_THRESHOLD: cfg_in.off_threshold = pwdata[11:0];
            hcdc_pkg::REG_MIN_RUN:       cfg_in.min_run_ms = pwdata[30:0];
            hcdc_pkg::REG_DEF_INTERVAL:  cfg_in.defrost_interval_ms = pwdata;
            hcdc_pkg::REG_DEF_DURATION:  cfg_in.defrost_duration_ms = pwdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_threshold        <= 12'sd400;
         cfg_ff.off_threshold       <= 12'sd352;
         cfg_ff.min_run_ms          <= 31'd300000;
         cfg_ff.defrost_interval_ms <= 32'd3600000;
         cfg_ff.defrost_duration_ms <= 32'd600000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         hcdc_pkg::REG_ON_THRESHOLD:
            prdata = {{(hcdc_pkg::DATA_W-hcdc_pkg::TEMP_W){cfg_ff.on_threshold[11]}},
                      cfg_ff.on_threshold};
         hcdc_pkg::REG_OFF_THRESHOLD:
            prdata = {{(hcdc_pkg::DATA_W-hcdc_pkg::TEMP_W){cfg_ff.off_threshold[11]}},
                      cfg_ff.off_threshold};
         hcdc_pkg::REG_MIN_RUN:      prdata = {1'b0, cfg_ff.min_run_ms};
         hcdc_pkg::REG_DEF_INTERVAL: prdata = cfg_ff.defrost_interval_ms;
         hcdc_pkg::REG_DEF_DURATION: prdata = cfg_ff.defrost_duration_ms;
         default:                    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/hcdc_accum.sv */
// Running sum and count of tank readings for one evaluation.
module hcdc_accum #(
   parameter int MAX_TANKS = 16,
   parameter int CW        = 5,
   parameter int SW        = 17
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic                               last,
   input  logic signed [hcdc_pkg::TEMP_W-1:0] temp,
   output logic signed [SW-1:0]               sum_total,
   output logic [CW-1:0]                      count_total
);

   logic signed [SW-1:0] sum_ff;
   logic signed [SW-1:0] sum_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic                 room;

   assign room = count_ff < CW'(MAX_TANKS);

   always_comb begin
      sum_total   = sum_ff;
      count_total = count_ff;
      if (room) begin
         sum_total   = sum_ff + {{(SW-hcdc_pkg::TEMP_W){temp[hcdc_pkg::TEMP_W-1]}}, temp};
         count_total = count_ff + CW'(1);
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (step) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_total;
            count_in = count_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/hcdc_ctrl.sv */
// Hysteresis, run-time limits and defrost sequencing on each evaluation.
module hcdc_ctrl #(
   parameter int CW = 5,
   parameter int SW = 17
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               eval,
   input  logic signed [SW-1:0]               sum,
   input  logic [CW-1:0]                      count,
   input  logic [hcdc_pkg::TIME_W-1:0]        now,
   input  hcdc_pkg::cfg_type                  cfg,
   output hcdc_pkg::result_type               res
);

   localparam int PW = hcdc_pkg::TEMP_W + CW + 1;

   logic                        comp_ff, comp_in;
   logic                        fan_ff, fan_in;
   logic                        defrost_ff, defrost_in;
   logic [hcdc_pkg::TIME_W-1:0] run_start_ff, run_start_in;
   logic [hcdc_pkg::TIME_W-1:0] def_start_ff, def_start_in;

   logic signed [PW-1:0]        cnt_s, on_s, off_s, sum_s, on_prod, off_prod;
   logic                        want_run, want_stop;
   logic [hcdc_pkg::TIME_W-1:0] def_elapsed, ran, max_run;
   hcdc_pkg::action_type        action;

   assign cnt_s    = $signed({{(PW-CW){1'b0}}, count});
   assign on_s     = {{(PW-hcdc_pkg::TEMP_W){cfg.on_threshold[11]}}, cfg.on_threshold};
   assign off_s    = {{(PW-hcdc_pkg::TEMP_W){cfg.off_threshold[11]}}, cfg.off_threshold};
   assign sum_s    = {{(PW-SW){sum[SW-1]}}, sum};
   assign on_prod  = on_s * cnt_s;
   assign off_prod = off_s * cnt_s;
   assign want_run  = sum_s > on_prod;
   assign want_stop = sum_s < off_prod;

   assign def_elapsed = now - def_start_ff;
   assign ran         = now - run_start_ff;
   assign max_run     = {cfg.min_run_ms, 1'b0};

   always_comb begin
      comp_in      = comp_ff;
      fan_in       = fan_ff;
      defrost_in   = defrost_ff;
      run_start_in = run_start_ff;
      def_start_in = def_start_ff;
      action       = hcdc_pkg::ACT_HOLD;
      if (defrost_ff) begin
         if (def_elapsed >= cfg.defrost_duration_ms) begin
            defrost_in = 1'b0;
            action     = hcdc_pkg::ACT_DEF_END;
         end else begin
            action = hcdc_pkg::ACT_DEFROSTING;
         end
      end else if (def_elapsed >= cfg.defrost_interval_ms) begin
         comp_in      = 1'b0;
         fan_in       = 1'b0;
         defrost_in   = 1'b1;
         def_start_in = now;
         action       = hcdc_pkg::ACT_DEF_START;
      end else begin
         if (want_run && !comp_ff) begin
            comp_in      = 1'b1;
            run_start_in = now;
            action       = hcdc_pkg::ACT_START;
         end else if (comp_ff && want_stop && ran >= {1'b0, cfg.min_run_ms}) begin
            comp_in = 1'b0;
            action  = hcdc_pkg::ACT_LOW_STOP;
         end else if (comp_ff && ran >= max_run) begin
            comp_in = 1'b0;
            action  = hcdc_pkg::ACT_MAX_STOP;
         end
         fan_in = comp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff      <= 1'b0;
         fan_ff       <= 1'b0;
         defrost_ff   <= 1'b0;
         run_start_ff <= '0;
         def_start_ff <= '0;
      end else if (eval) begin
         comp_ff      <= comp_in;
         fan_ff       <= fan_in;
         defrost_ff   <= defrost_in;
         run_start_ff <= run_start_in;
         def_start_ff <= def_start_in;
      end
   end

   assign res.compressor_on = comp_in;
   assign res.fan_on        = fan_in;
   assign res.heater_on     = defrost_in;
   assign res.action        = action;

endmodule

/* hw/rtl/hysteresis_compressor_defrost_ctrl_top.sv */
// Top level of the compressor hysteresis and defrost controller.
// Tank readings enter one per cycle into an input register; the block then adds the
// reading to the running sum and, on the reading flagged last, evaluates hysteresis,
// run-time limits and defrost in one pass and loads the result register. The result of
// a last reading reaches the rsp port through the input and result registers, and
// a new reading is accepted every cycle; the input side stalls only while a last reading
// waits for a result register still holding an untaken result. Readings past MAX_TANKS
// in one evaluation add nothing but still close it when flagged last. The user must
// write registers over the csr port only while no transaction is in flight; not enforced.
module hysteresis_compressor_defrost_ctrl_top #(
   parameter int MAX_TANKS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [hcdc_pkg::TEMP_W-1:0] req_tank_temp,
   input  logic                               req_is_last,
   input  logic [hcdc_pkg::TIME_W-1:0]        req_now_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_compressor_on,
   output logic                               rsp_fan_on,
   output logic                               rsp_heater_on,
   output logic [2:0]                         rsp_action,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hcdc_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [hcdc_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [hcdc_pkg::DATA_W-1:0]        csr_prdata,
   output logic                               csr_pready
);

   localparam int CW = $clog2(MAX_TANKS + 1);
   localparam int SW = hcdc_pkg::TEMP_W + CW;

   hcdc_pkg::cfg_type    cfg;
   hcdc_pkg::result_type res;
   hcdc_pkg::result_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                               in_valid_ff, in_valid_in;
   logic                               in_last_ff;
   logic signed [hcdc_pkg::TEMP_W-1:0] in_temp_ff;
   logic [hcdc_pkg::TIME_W-1:0]        in_now_ff;

   logic                 out_free, hold, step, eval;
   logic signed [SW-1:0] sum_total;
   logic [CW-1:0]        count_total;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign hold      = in_valid_ff && in_last_ff && !out_free;
   assign req_ready = !hold;
   assign step      = in_valid_ff && !hold;
   assign eval      = step && in_last_ff;

   assign in_valid_in = hold ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_temp_ff <= req_tank_temp;
         in_last_ff <= req_is_last;
         in_now_ff  <= req_now_ms;
      end
   end

   hcdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   hcdc_accum #(
      .MAX_TANKS (MAX_TANKS),
      .CW        (CW),
      .SW        (SW)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .last        (in_last_ff),
      .temp        (in_temp_ff),
      .sum_total   (sum_total),
      .count_total (count_total)
   );

   hcdc_ctrl #(
      .CW (CW),
      .SW (SW)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .eval  (eval),
      .sum   (sum_total),
      .count (count_total),
      .now   (in_now_ff),
      .cfg   (cfg),
      .res   (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (eval) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compressor_on = rsp_ff.compressor_on;
   assign rsp_fan_on        = rsp_ff.fan_on;
   assign rsp_heater_on     = rsp_ff.heater_on;
   assign rsp_action        = rsp_ff.action;
   assign csr_pready        = 1'b1;

`ifndef SYNTH
   a_heater_excludes_comp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_heater_on && rsp_compressor_on))
      else $error("heater and compressor driven together");

   a_fan_follows_comp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fan_on == rsp_compressor_on))
      else $error("fan does not follow compressor");

   a_start_turns_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == hcdc_pkg::ACT_START) |-> rsp_compressor_on)
      else $error("start transaction without compressor on");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_action)))
      else $error("pending transaction lost");
`endif

endmodule
